@@ src/spfe_pkg.sv @@
// Shared types, constants and distance helper for the slot pool.
`timescale 1ns / 1ps

package spfe_pkg;

    localparam int POS_W      = 21;
    localparam int DIFF_W     = POS_W + 1;
    localparam int DIST_SHIFT = 8;
    localparam int Q_W        = DIFF_W - DIST_SHIFT;
    localparam int SQ_W       = 2 * Q_W - 1;
    localparam int DIST_W     = SQ_W + 1;
    localparam int ID_W       = 8;
    localparam int SLOT_IDX_W = 6;
    localparam int OP_W       = 2;

    localparam logic [OP_W-1:0] OP_ENABLE  = 2'd0;
    localparam logic [OP_W-1:0] OP_DISABLE = 2'd1;
    localparam logic [OP_W-1:0] OP_UPDATE  = 2'd2;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } pos_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    // ((p - c) >>> 8) squared; the product is never negative
    function automatic logic [SQ_W-1:0] axis_sq(
        input logic signed [POS_W-1:0] p,
        input logic signed [POS_W-1:0] c
    );
        logic signed [DIFF_W-1:0]  d;
        logic signed [Q_W-1:0]     q;
        logic signed [2*Q_W-1:0]   prod;
        d    = DIFF_W'(p) - DIFF_W'(c);
        q    = Q_W'(d >>> DIST_SHIFT);
        prod = q * q;
        return prod[SQ_W-1:0];
    endfunction

endpackage

@@ src/slot_pool_farthest_eviction.sv @@
// Slot pool with owner lookup, free-slot allocation and farthest-occupant eviction.
`timescale 1ns / 1ps

// A new request is taken only in IDLE; in_stall holds the input off while the sweep
// reads every entry of the slot memory once through its single read port, and while
// the result waits in DECIDE for the result register to be free.
// Reset: every slot free, both channels idle; the slot memories are not cleared,
// an entry is only read as meaningful while its busy bit is set.
module slot_pool_farthest_eviction #(
    parameter int SLOTS      = 8,
    parameter int OWNER_BITS = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [spfe_pkg::OP_W-1:0]              operation,
    input  logic [spfe_pkg::ID_W-1:0]              owner_id,
    input  logic                                   always_grant,
    input  logic signed [spfe_pkg::POS_W-1:0]      pos_x,
    input  logic signed [spfe_pkg::POS_W-1:0]      pos_y,
    input  logic signed [spfe_pkg::POS_W-1:0]      pos_z,
    input  logic signed [spfe_pkg::POS_W-1:0]      cam_x,
    input  logic signed [spfe_pkg::POS_W-1:0]      cam_y,
    input  logic signed [spfe_pkg::POS_W-1:0]      cam_z,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   granted,
    output logic [spfe_pkg::SLOT_IDX_W-1:0]        slot_index,
    output logic                                   evicted,
    output logic [spfe_pkg::ID_W-1:0]              evicted_owner
);

    // Owner ids wider than the port carry no extra bits
    localparam int OWN_W = (OWNER_BITS < spfe_pkg::ID_W) ? OWNER_BITS : spfe_pkg::ID_W;
    localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = $clog2(SLOTS + 1);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    spfe_pkg::state_t state_reg, state_next;

    // Busy bits live in flops so the free-slot search is immediate
    logic [SLOTS-1:0] busy_reg;

    // Slot memories: owner id and stored position, one read port each
    logic [OWN_W-1:0]  owner_mem [SLOTS];
    spfe_pkg::pos_t    pos_mem   [SLOTS];
    logic [OWN_W-1:0]  owner_q;
    spfe_pkg::pos_t    pos_q;

    // Request held for the whole sweep
    logic [spfe_pkg::OP_W-1:0] req_op_reg;
    logic [OWN_W-1:0]          req_owner_reg;
    logic                      req_always_reg;
    spfe_pkg::pos_t            req_pos_reg;
    spfe_pkg::pos_t            req_cam_reg;

    // Sweep read counter
    logic [CW-1:0] rd_cnt_reg;
    logic          mem_re;
    logic [IW-1:0] rd_idx;

    // Stage 1: memory data (or requester position on the first beat)
    logic          p1_vld_reg;
    logic          p1_bar_reg;
    logic [IW-1:0] p1_idx_reg;

    // Stage 2: squared axis distances
    logic                     p2_vld_reg;
    logic                     p2_bar_reg;
    logic                     p2_match_reg;
    logic [IW-1:0]            p2_idx_reg;
    logic [OWN_W-1:0]         p2_owner_reg;
    logic [spfe_pkg::SQ_W-1:0] p2_sqx_reg, p2_sqy_reg, p2_sqz_reg;

    // Stage 3: running farthest occupant and owner match
    logic                        best_vld_reg;
    logic [spfe_pkg::DIST_W-1:0] best_dist_reg;
    logic [IW-1:0]               best_idx_reg;
    logic [OWN_W-1:0]            best_owner_reg;
    logic                        found_reg;
    logic [IW-1:0]               found_idx_reg;

    // Result register
    logic                             out_valid_reg;
    logic                             granted_reg;
    logic [spfe_pkg::SLOT_IDX_W-1:0]  slot_index_reg;
    logic                             evicted_reg;
    logic [spfe_pkg::ID_W-1:0]        evicted_owner_reg;

    logic in_xfer;
    logic out_free;
    logic scan_last;

    assign in_stall = (state_reg != spfe_pkg::ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign out_valid     = out_valid_reg;
    assign granted       = granted_reg;
    assign slot_index    = slot_index_reg;
    assign evicted       = evicted_reg;
    assign evicted_owner = evicted_owner_reg;

    // ------------------------------------------------------------------
    // Lowest free slot from the busy flops
    // ------------------------------------------------------------------
    logic          free_any;
    logic [IW-1:0] free_idx;

    always_comb
    begin
        free_any = ~&busy_reg;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                free_idx = IW'(i);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: idle, sweep the memory, then decide and write back.
    // A write-back only ever happens in DECIDE and the next sweep starts
    // after it, so reads never overlap a pending write to the same entry.
    // ------------------------------------------------------------------
    logic                             mem_we;
    logic [IW-1:0]                    wr_idx;
    logic                             busy_clr;
    logic                             load_out;
    logic                             res_granted;
    logic [spfe_pkg::SLOT_IDX_W-1:0]  res_idx;
    logic                             res_evicted;
    logic [spfe_pkg::ID_W-1:0]        res_evicted_owner;

    assign mem_re    = (state_reg == spfe_pkg::ST_SCAN) && (rd_cnt_reg < CW'(SLOTS));
    assign rd_idx    = rd_cnt_reg[IW-1:0];
    assign scan_last = p2_vld_reg && !p2_bar_reg && (p2_idx_reg == IW'(SLOTS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spfe_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        mem_we            = 1'b0;
        wr_idx            = found_idx_reg;
        busy_clr          = 1'b0;
        load_out          = 1'b0;
        res_granted       = 1'b0;
        res_idx           = '0;
        res_evicted       = 1'b0;
        res_evicted_owner = '0;

        case (state_reg)
            spfe_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = spfe_pkg::ST_SCAN;
                end
            end
            spfe_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = spfe_pkg::ST_DECIDE;
                end
            end
            spfe_pkg::ST_DECIDE:
            begin
                // hold until the result register can take the new result
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = spfe_pkg::ST_IDLE;
                    case (req_op_reg)
                        spfe_pkg::OP_ENABLE:
                        begin
                            if (found_reg)
                            begin
                                // holder: refresh position, keep slot
                                mem_we      = 1'b1;
                                wr_idx      = found_idx_reg;
                                res_granted = 1'b1;
                                res_idx     = spfe_pkg::SLOT_IDX_W'(found_idx_reg);
                            end
                            else if (free_any)
                            begin
                                mem_we      = 1'b1;
                                wr_idx      = free_idx;
                                res_granted = 1'b1;
                                res_idx     = spfe_pkg::SLOT_IDX_W'(free_idx);
                            end
                            else if (best_vld_reg)
                            begin
                                // pool full: displace the farthest occupant
                                mem_we            = 1'b1;
                                wr_idx            = best_idx_reg;
                                res_granted       = 1'b1;
                                res_idx           = spfe_pkg::SLOT_IDX_W'(best_idx_reg);
                                res_evicted       = 1'b1;
                                res_evicted_owner = spfe_pkg::ID_W'(best_owner_reg);
                            end
                        end
                        spfe_pkg::OP_DISABLE:
                        begin
                            busy_clr = found_reg;
                        end
                        spfe_pkg::OP_UPDATE:
                        begin
                            if (found_reg)
                            begin
                                // owner rewritten with the same id
                                mem_we      = 1'b1;
                                wr_idx      = found_idx_reg;
                                res_granted = 1'b1;
                                res_idx     = spfe_pkg::SLOT_IDX_W'(found_idx_reg);
                            end
                        end
                        default:
                        begin
                            // unused operation code: empty result
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = spfe_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Slot memories
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            owner_mem[wr_idx] <= req_owner_reg;
            pos_mem[wr_idx]   <= req_pos_reg;
        end
        if (mem_re)
        begin
            owner_q <= owner_mem[rd_idx];
            pos_q   <= pos_mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else if (mem_we)
        begin
            busy_reg[wr_idx] <= 1'b1;
        end
        else if (busy_clr)
        begin
            busy_reg[found_idx_reg] <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Request capture and sweep counter
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            req_op_reg     <= operation;
            req_owner_reg  <= owner_id[OWN_W-1:0];
            req_always_reg <= always_grant;
            req_pos_reg    <= '{x: pos_x, y: pos_y, z: pos_z};
            req_cam_reg    <= '{x: cam_x, y: cam_y, z: cam_z};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_cnt_reg <= '0;
        end
        else if (in_xfer)
        begin
            rd_cnt_reg <= '0;
        end
        else if (mem_re)
        begin
            rd_cnt_reg <= rd_cnt_reg + CW'(1);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 tag: the beat after the transfer carries the requester's
    // own position (the eviction bar), then one beat per slot.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p1_bar_reg <= 1'b0;
        end
        else
        begin
            p1_vld_reg <= in_xfer || mem_re;
            p1_bar_reg <= in_xfer;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_idx_reg <= rd_idx;
    end

    // ------------------------------------------------------------------
    // Stage 2: per-axis squares, owner match
    // ------------------------------------------------------------------
    spfe_pkg::pos_t sq_src;
    logic           p1_match;

    assign sq_src   = p1_bar_reg ? req_pos_reg : pos_q;
    assign p1_match = !p1_bar_reg && busy_reg[p1_idx_reg] && (owner_q == req_owner_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_vld_reg <= 1'b0;
            p2_bar_reg <= 1'b0;
        end
        else
        begin
            p2_vld_reg <= p1_vld_reg;
            p2_bar_reg <= p1_vld_reg && p1_bar_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p2_match_reg <= p1_match;
        p2_idx_reg   <= p1_idx_reg;
        p2_owner_reg <= owner_q;
        p2_sqx_reg   <= spfe_pkg::axis_sq(sq_src.x, req_cam_reg.x);
        p2_sqy_reg   <= spfe_pkg::axis_sq(sq_src.y, req_cam_reg.y);
        p2_sqz_reg   <= spfe_pkg::axis_sq(sq_src.z, req_cam_reg.z);
    end

    // ------------------------------------------------------------------
    // Stage 3: sum, strict compare against the bar / current farthest.
    // The lower slot index wins ties because only a strictly larger sum replaces.
    // ------------------------------------------------------------------
    logic [spfe_pkg::DIST_W-1:0] p2_dist;
    logic                        farther;

    assign p2_dist = spfe_pkg::DIST_W'(p2_sqx_reg) + spfe_pkg::DIST_W'(p2_sqy_reg)
                   + spfe_pkg::DIST_W'(p2_sqz_reg);
    assign farther = p2_dist > best_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_vld_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else if (in_xfer)
        begin
            best_vld_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else if (p2_vld_reg && !p2_bar_reg)
        begin
            if (farther)
            begin
                best_vld_reg <= 1'b1;
            end
            if (p2_match_reg)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p2_vld_reg && p2_bar_reg)
        begin
            best_dist_reg <= req_always_reg ? '0 : p2_dist;
        end
        else if (p2_vld_reg && farther)
        begin
            best_dist_reg  <= p2_dist;
            best_idx_reg   <= p2_idx_reg;
            best_owner_reg <= p2_owner_reg;
        end
        if (p2_vld_reg && !p2_bar_reg && p2_match_reg && !found_reg)
        begin
            found_idx_reg <= p2_idx_reg;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            granted_reg       <= res_granted;
            slot_index_reg    <= res_idx;
            evicted_reg       <= res_evicted;
            evicted_owner_reg <= res_evicted_owner;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_busy_stable_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spfe_pkg::ST_SCAN) |=> $stable(busy_reg) || ($past(busy_reg) == busy_reg))
        else $error("busy bits changed during a sweep");

    a_evict_implies_grant: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && evicted_reg |-> granted_reg)
        else $error("eviction reported without a grant");

    a_granted_slot_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && granted_reg |-> busy_reg[slot_index_reg[IW-1:0]])
        else $error("granted slot is not busy");

    a_result_ends_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (state_reg == spfe_pkg::ST_IDLE) && out_valid_reg)
        else $error("result load did not return the sequencer to idle");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rd_cnt_reg <= CW'(SLOTS))
        else $error("sweep counter ran past the pool");

endmodule
